@@ hdl/cfv_pkg.sv @@
package cfv_pkg;

  localparam int unsigned BASE_LEN = 15;
  localparam logic [15:0] MAX_COUNT = 16'hFFFF;
  localparam logic [15:0] MIN_FRAME = 16'd6;
  localparam logic [31:0] POST_WORD = 32'h212A2340;

  localparam logic [7:0] PRE_CHARS [4] = '{8'h24, 8'h2A, 8'h26, 8'h3F};

  localparam logic [15:0] CODE_P1 = 16'h5031;
  localparam logic [15:0] CODE_P2 = 16'h5032;
  localparam logic [15:0] CODE_GD = 16'h4744;
  localparam logic [15:0] CODE_SU = 16'h5355;
  localparam logic [15:0] CODE_LG = 16'h4C47;
  localparam logic [15:0] CODE_NC = 16'h2143;
  localparam logic [15:0] CODE_FW = 16'h4657;
  localparam logic [15:0] CODE_UD = 16'h5544;
  localparam logic [15:0] CODE_CP = 16'h4350;

  typedef enum logic [3:0] {
    CMD_P1      = 4'd0,
    CMD_P2      = 4'd1,
    CMD_GD      = 4'd2,
    CMD_SU      = 4'd3,
    CMD_LG      = 4'd4,
    CMD_NC      = 4'd5,
    CMD_FW      = 4'd6,
    CMD_UD      = 4'd7,
    CMD_CP      = 4'd8,
    CMD_UNKNOWN = 4'd9
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_LENGTH    = 3'd2,
    ST_PREAMBLE  = 3'd3,
    ST_POSTAMBLE = 3'd4,
    ST_CHECKSUM  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } cfv_beat_t;

  typedef struct packed {
    cmd_t        command_code;
    status_t     frame_status;
    logic [31:0] payload_word_low;
    logic [31:0] payload_word_high;
  } cfv_result_t;

  function automatic cmd_t cmd_decode(logic [15:0] cb);
    cmd_t c;
    unique case (cb)
      CODE_P1: c = CMD_P1;
      CODE_P2: c = CMD_P2;
      CODE_GD: c = CMD_GD;
      CODE_SU: c = CMD_SU;
      CODE_LG: c = CMD_LG;
      CODE_NC: c = CMD_NC;
      CODE_FW: c = CMD_FW;
      CODE_UD: c = CMD_UD;
      CODE_CP: c = CMD_CP;
      default: c = CMD_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/cfv_in_reg.sv @@
module cfv_in_reg
  import cfv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [7:0] in_byte_value,
  input  logic      in_last_byte,
  input  logic      out_busy,
  output logic      beat_fire,
  output cfv_beat_t beat
);

  logic      s_valid_r;
  cfv_beat_t s_beat_r;
  logic      hold;

  // only a closing beat needs the result register free
  assign hold      = s_valid_r && s_beat_r.last_byte && out_busy;
  assign in_stall  = hold;
  assign beat_fire = s_valid_r && !hold;
  assign beat      = s_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (!hold) begin
      s_valid_r <= in_valid;
    end
    if (!hold) begin
      s_beat_r.byte_value <= in_byte_value;
      s_beat_r.last_byte  <= in_last_byte;
    end
  end

endmodule

@@ hdl/cfv_check.sv @@
module cfv_check
  import cfv_pkg::*;
#(
  parameter int unsigned SETUP_PAYLOAD_BYTES = 64,
  parameter int unsigned UPDATE_BLOCK_BYTES  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        beat_fire,
  input  cfv_beat_t   beat,
  output logic        res_valid,
  output cfv_result_t res
);

  function automatic logic [15:0] frame_len(cmd_t c);
    logic [15:0] len;
    case (c)
      CMD_GD:  len = 16'(BASE_LEN + 4);
      CMD_SU:  len = 16'(BASE_LEN + SETUP_PAYLOAD_BYTES);
      CMD_LG:  len = 16'(BASE_LEN + 8);
      CMD_FW:  len = 16'(BASE_LEN + 13);
      CMD_UD:  len = 16'(BASE_LEN + 2 + UPDATE_BLOCK_BYTES);
      CMD_CP:  len = 16'(BASE_LEN + 2);
      default: len = 16'(BASE_LEN);
    endcase
    return len;
  endfunction

  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        pre_ok_r, pre_ok_nxt;
  logic [15:0] cb_r, cb_nxt;
  logic [15:0] elen_r, elen_nxt;
  logic [7:0]  fsum_r, fsum_nxt;
  logic [7:0]  rchk_r, rchk_nxt;
  logic [31:0] tail_r, tail_nxt;
  logic [31:0] plo_r, plo_nxt;
  logic [31:0] phi_r, phi_nxt;

  logic [7:0]  b;
  logic [15:0] cap_pos;
  logic [15:0] off;
  logic [31:0] lane_val;
  cmd_t        cb_cmd;
  cmd_t        cmd;
  status_t     status;

  assign b       = beat.byte_value;
  assign cap_pos = elen_r - 16'd5;
  assign off     = cnt_r - 16'd10;
  assign lane_val = 32'(b) << {off[1:0], 3'b000};

  always_comb begin
    pre_ok_nxt = pre_ok_r;
    cb_nxt     = cb_r;
    elen_nxt   = elen_r;
    fsum_nxt   = fsum_r;
    rchk_nxt   = rchk_r;
    plo_nxt    = plo_r;
    phi_nxt    = phi_r;

    if (cnt_r < 16'd4 && b != PRE_CHARS[cnt_r[1:0]]) begin
      pre_ok_nxt = 1'b0;
    end
    if (cnt_r == 16'd4 || cnt_r == 16'd5) begin
      cb_nxt = {cb_r[7:0], b};
    end
    cb_cmd = cmd_decode(cb_nxt);
    if (cnt_r == 16'd5) begin
      elen_nxt = (cb_cmd == CMD_UNKNOWN) ? 16'd0 : frame_len(cb_cmd);
    end
    if (elen_r != 16'd0) begin
      if (cnt_r == cap_pos) begin
        fsum_nxt = sum_r;
        rchk_nxt = b;
      end
      if (cnt_r >= 16'd10 && cnt_r < 16'd18 && cnt_r < cap_pos) begin
        if (off[2]) begin
          phi_nxt = phi_r | lane_val;
        end else begin
          plo_nxt = plo_r | lane_val;
        end
      end
    end

    sum_nxt  = sum_r + b;
    tail_nxt = {tail_r[23:0], b};
    cnt_nxt  = (cnt_r == MAX_COUNT) ? cnt_r : cnt_r + 16'd1;

    cmd = (cnt_nxt < MIN_FRAME) ? CMD_UNKNOWN : cb_cmd;
    if (cmd == CMD_UNKNOWN) begin
      status = ST_UNKNOWN;
    end else if (cnt_nxt != frame_len(cmd)) begin
      status = ST_LENGTH;
    end else if (!pre_ok_nxt) begin
      status = ST_PREAMBLE;
    end else if (tail_nxt != POST_WORD) begin
      status = ST_POSTAMBLE;
    end else if ((cmd == CMD_LG || cmd == CMD_UD || cmd == CMD_CP) &&
                 fsum_nxt != rchk_nxt) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_OK;
    end

    res.command_code      = cmd;
    res.frame_status      = status;
    res.payload_word_low  = (cmd == CMD_UNKNOWN) ? 32'd0 : plo_nxt;
    res.payload_word_high = (cmd == CMD_UNKNOWN) ? 32'd0 : phi_nxt;
  end

  assign res_valid = beat_fire && beat.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      cnt_r    <= 16'd0;
      sum_r    <= 8'd0;
      pre_ok_r <= 1'b1;
      cb_r     <= 16'd0;
      elen_r   <= 16'd0;
      fsum_r   <= 8'd0;
      rchk_r   <= 8'd0;
      tail_r   <= 32'd0;
      plo_r    <= 32'd0;
      phi_r    <= 32'd0;
    end else if (beat_fire) begin
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
      pre_ok_r <= pre_ok_nxt;
      cb_r     <= cb_nxt;
      elen_r   <= elen_nxt;
      fsum_r   <= fsum_nxt;
      rchk_r   <= rchk_nxt;
      tail_r   <= tail_nxt;
      plo_r    <= plo_nxt;
      phi_r    <= phi_nxt;
    end
  end

endmodule

@@ hdl/cfv_out_reg.sv @@
module cfv_out_reg
  import cfv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  cfv_result_t res,
  output logic        out_busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_command_code,
  output logic [2:0]  out_frame_status,
  output logic [31:0] out_payload_word_low,
  output logic [31:0] out_payload_word_high
);

  logic        valid_r;
  cfv_result_t res_r;

  assign out_busy              = valid_r && out_stall;
  assign out_valid             = valid_r;
  assign out_command_code      = res_r.command_code;
  assign out_frame_status      = res_r.frame_status;
  assign out_payload_word_low  = res_r.payload_word_low;
  assign out_payload_word_high = res_r.payload_word_high;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
    if (load) begin
      res_r <= res;
    end
  end

endmodule

@@ hdl/command_frame_validator.sv @@
// A closing beat passes through the input register, then its result is loaded into the result register.
// Throughput: one byte per cycle while in_stall is low, set by the single input-register to result-register pass.
// A closing beat waits in the input register only while an earlier result is still stalled.
// Reset: synchronous, active low; clears the frame state, both valid flags and all counters.
module command_frame_validator
  import cfv_pkg::*;
#(
  parameter int unsigned SETUP_PAYLOAD_BYTES = 64,
  parameter int unsigned UPDATE_BLOCK_BYTES  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_command_code,
  output logic [2:0]  out_frame_status,
  output logic [31:0] out_payload_word_low,
  output logic [31:0] out_payload_word_high
);

  logic        out_busy;
  logic        beat_fire;
  cfv_beat_t   beat;
  logic        res_valid;
  cfv_result_t res;

  cfv_in_reg u_in_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_value (in_byte_value),
    .in_last_byte  (in_last_byte),
    .out_busy      (out_busy),
    .beat_fire     (beat_fire),
    .beat          (beat)
  );

  cfv_check #(
    .SETUP_PAYLOAD_BYTES (SETUP_PAYLOAD_BYTES),
    .UPDATE_BLOCK_BYTES  (UPDATE_BLOCK_BYTES)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_fire (beat_fire),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  cfv_out_reg u_out_reg (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .load                  (res_valid),
    .res                   (res),
    .out_busy              (out_busy),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_command_code      (out_command_code),
    .out_frame_status      (out_frame_status),
    .out_payload_word_low  (out_payload_word_low),
    .out_payload_word_high (out_payload_word_high)
  );

endmodule

@@ sim/cfv_frame_checker.sv @@
module cfv_frame_checker
  import cfv_pkg::*;
#(
  parameter int unsigned SETUP_PAYLOAD_BYTES = 64,
  parameter int unsigned UPDATE_BLOCK_BYTES  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_command_code,
  input  logic [2:0]  out_frame_status,
  input  logic [31:0] out_payload_word_low,
  input  logic [31:0] out_payload_word_high,
  output int          mismatches,
  output int          verdicts_due
);

  cfv_result_t pending_verdicts [$];

  logic [15:0] byte_cnt;
  logic [7:0]  sum_acc;
  logic [7:0]  sum_at_check;
  logic [7:0]  check_byte;
  logic        preamble_ok;
  logic [15:0] code_word;
  logic [15:0] len_due;
  logic [31:0] last_four;
  logic [31:0] pay_lo;
  logic [31:0] pay_hi;

  function automatic cmd_t command_of(logic [15:0] w);
    case (w)
      CODE_P1: return CMD_P1;
      CODE_P2: return CMD_P2;
      CODE_GD: return CMD_GD;
      CODE_SU: return CMD_SU;
      CODE_LG: return CMD_LG;
      CODE_NC: return CMD_NC;
      CODE_FW: return CMD_FW;
      CODE_UD: return CMD_UD;
      CODE_CP: return CMD_CP;
      default: return CMD_UNKNOWN;
    endcase
  endfunction

  function automatic logic [15:0] frame_length_of(cmd_t c);
    case (c)
      CMD_GD:  return 16'(BASE_LEN + 4);
      CMD_SU:  return 16'(BASE_LEN + SETUP_PAYLOAD_BYTES);
      CMD_LG:  return 16'(BASE_LEN + 8);
      CMD_FW:  return 16'(BASE_LEN + 13);
      CMD_UD:  return 16'(BASE_LEN + 2 + UPDATE_BLOCK_BYTES);
      CMD_CP:  return 16'(BASE_LEN + 2);
      default: return 16'(BASE_LEN);
    endcase
  endfunction

  task automatic clear_frame();
    byte_cnt     = '0;
    sum_acc      = '0;
    sum_at_check = '0;
    check_byte   = '0;
    preamble_ok  = 1'b1;
    code_word    = '0;
    len_due      = '0;
    last_four    = '0;
    pay_lo       = '0;
    pay_hi       = '0;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    int unsigned idx;
    int unsigned e;
    int unsigned k;
    cmd_t        c;
    status_t     st;
    cfv_result_t v;
    idx = byte_cnt;
    e   = len_due;
    if (idx < 4 && b != PRE_CHARS[idx]) preamble_ok = 1'b0;
    if (idx == 4 || idx == 5) code_word = {code_word[7:0], b};
    if (idx == 5) begin
      c = command_of(code_word);
      len_due = (c == CMD_UNKNOWN) ? 16'd0 : frame_length_of(c);
    end
    if (e != 0) begin
      if (idx == e - 5) begin
        sum_at_check = sum_acc;
        check_byte   = b;
      end
      if (idx >= 10 && idx < 18 && idx < e - 5) begin
        k = idx - 10;
        if (k < 4) pay_lo[k*8 +: 8] = pay_lo[k*8 +: 8] | b;
        else pay_hi[(k-4)*8 +: 8] = pay_hi[(k-4)*8 +: 8] | b;
      end
    end
    sum_acc   = sum_acc + b;
    last_four = {last_four[23:0], b};
    if (byte_cnt != MAX_COUNT) byte_cnt = byte_cnt + 16'd1;
    if (last) begin
      c = (byte_cnt < MIN_FRAME) ? CMD_UNKNOWN : command_of(code_word);
      if (c == CMD_UNKNOWN) st = ST_UNKNOWN;
      else if (byte_cnt != frame_length_of(c)) st = ST_LENGTH;
      else if (!preamble_ok) st = ST_PREAMBLE;
      else if (last_four != POST_WORD) st = ST_POSTAMBLE;
      else if ((c == CMD_LG || c == CMD_UD || c == CMD_CP) && sum_at_check != check_byte)
        st = ST_CHECKSUM;
      else st = ST_OK;
      v.command_code      = c;
      v.frame_status      = st;
      v.payload_word_low  = (c == CMD_UNKNOWN) ? 32'd0 : pay_lo;
      v.payload_word_high = (c == CMD_UNKNOWN) ? 32'd0 : pay_hi;
      pending_verdicts.push_back(v);
      clear_frame();
    end
  endtask

  always @(posedge clk) begin : watch
    cfv_result_t v;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      pending_verdicts.delete();
      clear_frame();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          $error("unexpected result beat: command_code %0d frame_status %0d",
                 out_command_code, out_frame_status);
          errs++;
        end else begin
          v = pending_verdicts.pop_front();
          if (out_command_code !== v.command_code) begin
            $error("command_code: expected %0d, got %0d", v.command_code, out_command_code);
            errs++;
          end
          if (out_frame_status !== v.frame_status) begin
            $error("frame_status: expected %0d, got %0d", v.frame_status, out_frame_status);
            errs++;
          end
          if (out_payload_word_low !== v.payload_word_low) begin
            $error("payload_word_low: expected %h, got %h",
                   v.payload_word_low, out_payload_word_low);
            errs++;
          end
          if (out_payload_word_high !== v.payload_word_high) begin
            $error("payload_word_high: expected %h, got %h",
                   v.payload_word_high, out_payload_word_high);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) take_byte(in_byte_value, in_last_byte);
    end
    mismatches   <= mismatches + errs;
    verdicts_due <= pending_verdicts.size();
  end

endmodule

@@ sim/tb_command_frame_validator.sv @@
module tb_command_frame_validator;
  import cfv_pkg::*;

  localparam int unsigned SETUP_BYTES  = 64;
  localparam int unsigned UPDATE_BYTES = 256;
  localparam int IDLE_LIMIT       = 2000;
  localparam int RANDOM_BYTES     = 150;
  localparam int RANDOM_FRAMES    = 2;
  localparam int END_CYCLES       = 8;

  typedef enum int {
    FLAW_NONE,
    FLAW_CODE,
    FLAW_PREAMBLE,
    FLAW_POSTAMBLE,
    FLAW_CHECKSUM
  } flaw_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic [7:0]  in_byte_value = 8'd0;
  logic        in_last_byte  = 1'b0;
  logic        out_stall     = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [3:0]  out_command_code;
  logic [2:0]  out_frame_status;
  logic [31:0] out_payload_word_low;
  logic [31:0] out_payload_word_high;
  int          mismatches;
  int          verdicts_due;

  logic [7:0]  frame_bytes [$];
  int          burst_left  = 0;
  int          bytes_sent  = 0;
  int          idle_cycles = 0;
  int          stall_phase = 0;
  logic [15:0] stall_pat   = 16'd0;
  logic [3:0]  stall_pos   = 4'd0;

  always #5 clk = ~clk;

  command_frame_validator #(
    .SETUP_PAYLOAD_BYTES(SETUP_BYTES),
    .UPDATE_BLOCK_BYTES (UPDATE_BYTES)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_byte_value        (in_byte_value),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_command_code     (out_command_code),
    .out_frame_status     (out_frame_status),
    .out_payload_word_low (out_payload_word_low),
    .out_payload_word_high(out_payload_word_high)
  );

  cfv_frame_checker #(
    .SETUP_PAYLOAD_BYTES(SETUP_BYTES),
    .UPDATE_BLOCK_BYTES (UPDATE_BYTES)
  ) u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_byte_value        (in_byte_value),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_command_code     (out_command_code),
    .out_frame_status     (out_frame_status),
    .out_payload_word_low (out_payload_word_low),
    .out_payload_word_high(out_payload_word_high),
    .mismatches           (mismatches),
    .verdicts_due         (verdicts_due)
  );

  // receiver: stall pattern re-chosen whenever stall_phase counts down to zero
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_phase <= $urandom_range(300, 20);
      case ($urandom_range(3, 0))
        0:       stall_pat <= 16'h0000;
        1:       stall_pat <= 16'h0FF0;
        default: stall_pat <= 16'($urandom) & 16'hFFFE;
      endcase
    end else begin
      stall_phase <= stall_phase - 1;
    end
    stall_pos <= stall_pos + 4'd1;
    out_stall <= stall_pat[stall_pos];
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int frame_size(cmd_t c);
    case (c)
      CMD_GD:  return BASE_LEN + 4;
      CMD_SU:  return BASE_LEN + SETUP_BYTES;
      CMD_LG:  return BASE_LEN + 8;
      CMD_FW:  return BASE_LEN + 13;
      CMD_UD:  return BASE_LEN + 2 + UPDATE_BYTES;
      CMD_CP:  return BASE_LEN + 2;
      default: return BASE_LEN;
    endcase
  endfunction

  function automatic logic [15:0] code_of(cmd_t c);
    case (c)
      CMD_P1:  return CODE_P1;
      CMD_P2:  return CODE_P2;
      CMD_GD:  return CODE_GD;
      CMD_SU:  return CODE_SU;
      CMD_LG:  return CODE_LG;
      CMD_NC:  return CODE_NC;
      CMD_FW:  return CODE_FW;
      CMD_UD:  return CODE_UD;
      default: return CODE_CP;
    endcase
  endfunction

  // extra pads (or trims) the body ahead of the checksum byte
  task automatic build_frame(input cmd_t c, input flaw_t flaw, input int extra);
    int          body;
    int          i;
    int          pos;
    logic [7:0]  sum;
    logic [15:0] code;
    body = frame_size(c) + extra - 5;
    code = code_of(c);
    frame_bytes.delete();
    for (i = 0; i < 4; i++) frame_bytes.push_back(PRE_CHARS[i]);
    frame_bytes.push_back(code[15:8]);
    frame_bytes.push_back(code[7:0]);
    while (frame_bytes.size() < body) frame_bytes.push_back(8'($urandom));
    sum = 8'd0;
    foreach (frame_bytes[j]) sum += frame_bytes[j];
    frame_bytes.push_back(sum);
    for (i = 0; i < 4; i++) frame_bytes.push_back(POST_WORD[8*(3-i) +: 8]);
    case (flaw)
      FLAW_CODE: begin
        frame_bytes[4] = 8'($urandom);
        frame_bytes[5] = 8'($urandom);
      end
      FLAW_PREAMBLE: begin
        pos = $urandom_range(3, 0);
        frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(255, 1));
      end
      FLAW_POSTAMBLE: begin
        pos = frame_bytes.size() - 1 - $urandom_range(3, 0);
        frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(255, 1));
      end
      FLAW_CHECKSUM: begin
        pos = frame_bytes.size() - 5;
        frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(255, 1));
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(300, 50)
                                               : $urandom_range(12, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_last_byte  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
    bytes_sent += frame_bytes.size();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int    k;
    int    n;
    int    r;
    int    frames;
    int    extra;
    cmd_t  c;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < CMD_UNKNOWN; k++) begin
      build_frame(cmd_t'(k), FLAW_NONE, 0);
      send_frame();
    end
    // too short to hold a command
    for (n = 1; n <= 5; n++) begin
      build_frame(CMD_P1, FLAW_NONE, 0);
      while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
      send_frame();
    end
    frame_bytes = '{8'hFF};
    send_frame();
    frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame();
    build_frame(CMD_GD, FLAW_CODE, 0);
    send_frame();
    build_frame(CMD_LG, FLAW_NONE, 1);
    send_frame();
    build_frame(CMD_GD, FLAW_NONE, -1);
    send_frame();
    build_frame(CMD_FW, FLAW_PREAMBLE, 0);
    send_frame();
    build_frame(CMD_CP, FLAW_POSTAMBLE, 0);
    send_frame();
    build_frame(CMD_LG, FLAW_CHECKSUM, 0);
    send_frame();
    build_frame(CMD_UD, FLAW_CHECKSUM, 0);
    send_frame();
    build_frame(CMD_CP, FLAW_CHECKSUM, 0);
    send_frame();
    // checksum is not checked on this command
    build_frame(CMD_GD, FLAW_CHECKSUM, 0);
    send_frame();
    drain_results();

    bytes_sent = 0;
    frames     = 0;
    while (bytes_sent < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
      r = $urandom_range(99, 0);
      c = (r < 4) ? CMD_UD : (r < 12) ? CMD_SU : cmd_t'($urandom_range(CMD_CP, CMD_P1));
      r = $urandom_range(99, 0);
      if (r < 55) begin
        build_frame(c, FLAW_NONE, 0);
      end else if (r < 85) begin
        case ($urandom_range(4, 0))
          0: build_frame(c, FLAW_CODE, 0);
          1: begin
            extra = $urandom_range(4, 1);
            if ($urandom_range(1, 0) == 0) extra = -extra;
            build_frame(c, FLAW_NONE, extra);
          end
          2: build_frame(c, FLAW_PREAMBLE, 0);
          3: build_frame(c, FLAW_POSTAMBLE, 0);
          default: build_frame(c, FLAW_CHECKSUM, 0);
        endcase
      end else begin
        n = $urandom_range(30, 1);
        frame_bytes.delete();
        repeat (n) frame_bytes.push_back(8'($urandom));
      end
      send_frame();
      frames++;
      if ($urandom_range(19, 0) == 0) drain_results();
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/cfv_pkg.sv
hdl/cfv_in_reg.sv
hdl/cfv_check.sv
hdl/cfv_out_reg.sv
hdl/command_frame_validator.sv
sim/cfv_frame_checker.sv
sim/tb_command_frame_validator.sv
